// ----- src/tmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// tmpu_pkg
// Shared constants, codes and control types for the tile map palette upload
// planner.
// ----------------------------------------------------------------------------
package tmpu_pkg;

	localparam int MAP_DEPTH      = 2048;
	localparam int MAP_AW         = $clog2(MAP_DEPTH);
	localparam int SCREEN_COLUMNS = 40;
	localparam int SCREEN_ROWS    = 28;
	localparam int MAX_TILES      = 512;
	localparam int UPC_W          = 4;

	// reset values of the config registers
	localparam logic [8:0]  FRAME_WIDTH_RST  = 9'd320;
	localparam logic [7:0]  FRAME_HEIGHT_RST = 8'd224;
	localparam logic [9:0]  TILE_COUNT_RST   = 10'd1;
	localparam logic [10:0] MAP_COUNT_RST    = 11'd1120;
	localparam logic        BANK_SELECT_RST  = 1'b0;

	// config register indexes
	localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_TILE_COUNT   = 3'd2;
	localparam logic [2:0] CFG_MAP_COUNT    = 3'd3;
	localparam logic [2:0] CFG_BANK_SELECT  = 3'd4;

	// commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_NEXT  = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	// result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_ARG  = 2'd2;

	// sources and memories
	localparam logic [1:0] SRC_TILE = 2'd0;
	localparam logic [1:0] SRC_MAP  = 2'd1;
	localparam logic [1:0] SRC_PAL  = 2'd2;
	localparam logic       MEM_VRAM = 1'b0;
	localparam logic       MEM_CRAM = 1'b1;

	// address map
	localparam logic [15:0] TILE_BASE      = 16'h0020;
	localparam logic [15:0] TILE_BANK_STEP = 16'h4000;
	localparam logic [15:0] MAP_BASE_B0    = 16'hA000;
	localparam logic [15:0] MAP_BASE_B1    = 16'hE000;
	localparam logic [15:0] PAL_BANK_STEP  = 16'd32;
	localparam logic [15:0] PAL_BYTES      = 16'd32;
	localparam logic [15:0] PLANE_B_B0     = 16'h8405;
	localparam logic [15:0] PLANE_B_B1     = 16'h8407;
	localparam logic [15:0] BANK_TILE_OFS  = 16'd512;
	localparam logic [15:0] BANK_FLAG      = 16'h2000;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_START,
		OP_LOAD,
		OP_NOTHING,
		OP_TILE,
		OP_ROW,
		OP_WORD,
		OP_PALETTE
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_START,
		C_LOAD,
		C_NOT_NEXT,
		C_NOTHING,
		C_TILE,
		C_MAP,
		C_MORE_WORDS
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic             take;
		logic             emit;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic no_item;
		logic is_start;
		logic is_load;
		logic not_next;
		logic nothing;
		logic tile;
		logic map;
		logic more_words;
	} flags_t;

endpackage

// ----- src/tmpu_ram.sv -----
// ----------------------------------------------------------------------------
// tmpu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tmpu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/tmpu_seq.sv -----
// ----------------------------------------------------------------------------
// tmpu_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module tmpu_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  tmpu_pkg::flags_t flags,
	output tmpu_pkg::ctrl_t  ctrl
);

	localparam logic [tmpu_pkg::UPC_W-1:0] S_WAIT  = 4'd0;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_START = 4'd8;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_LOAD  = 4'd10;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_NONE  = 4'd11;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_TILE  = 4'd12;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_ROW   = 4'd13;
	localparam logic [tmpu_pkg::UPC_W-1:0] S_WORD  = 4'd14;

	logic [tmpu_pkg::UPC_W-1:0] upc_q;
	logic                       taken;

	// control store: op, condition, take, emit, target
	always_comb begin
		case (upc_q)
			4'd0:  ctrl = '{tmpu_pkg::OP_LATCH,   tmpu_pkg::C_NO_ITEM,    1'b1, 1'b0, S_WAIT};
			4'd1:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_START,      1'b0, 1'b0, S_START};
			4'd2:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_LOAD,       1'b0, 1'b0, S_LOAD};
			4'd3:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_NOT_NEXT,   1'b0, 1'b0, S_WAIT};
			4'd4:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_NOTHING,    1'b0, 1'b0, S_NONE};
			4'd5:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_TILE,       1'b0, 1'b0, S_TILE};
			4'd6:  ctrl = '{tmpu_pkg::OP_NOP,     tmpu_pkg::C_MAP,        1'b0, 1'b0, S_ROW};
			4'd7:  ctrl = '{tmpu_pkg::OP_PALETTE, tmpu_pkg::C_ALWAYS,     1'b0, 1'b1, S_WAIT};
			4'd8:  ctrl = '{tmpu_pkg::OP_START,   tmpu_pkg::C_ALWAYS,     1'b0, 1'b1, S_WAIT};
			4'd10: ctrl = '{tmpu_pkg::OP_LOAD,    tmpu_pkg::C_ALWAYS,     1'b0, 1'b0, S_WAIT};
			4'd11: ctrl = '{tmpu_pkg::OP_NOTHING, tmpu_pkg::C_ALWAYS,     1'b0, 1'b1, S_WAIT};
			4'd12: ctrl = '{tmpu_pkg::OP_TILE,    tmpu_pkg::C_ALWAYS,     1'b0, 1'b1, S_WAIT};
			4'd13: ctrl = '{tmpu_pkg::OP_ROW,     tmpu_pkg::C_NEVER,      1'b0, 1'b1, S_WAIT};
			4'd14: ctrl = '{tmpu_pkg::OP_WORD,    tmpu_pkg::C_MORE_WORDS, 1'b0, 1'b1, S_WORD};
			default: ctrl = '{tmpu_pkg::OP_NOP,   tmpu_pkg::C_ALWAYS,     1'b0, 1'b0, S_WAIT};
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			tmpu_pkg::C_NEVER:      taken = 1'b0;
			tmpu_pkg::C_ALWAYS:     taken = 1'b1;
			tmpu_pkg::C_NO_ITEM:    taken = flags.no_item;
			tmpu_pkg::C_START:      taken = flags.is_start;
			tmpu_pkg::C_LOAD:       taken = flags.is_load;
			tmpu_pkg::C_NOT_NEXT:   taken = flags.not_next;
			tmpu_pkg::C_NOTHING:    taken = flags.nothing;
			tmpu_pkg::C_TILE:       taken = flags.tile;
			tmpu_pkg::C_MAP:        taken = flags.map;
			tmpu_pkg::C_MORE_WORDS: taken = flags.more_words;
			default:                taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_WAIT;
		end else if (advance) begin
			upc_q <= taken ? ctrl.target : upc_q + 4'd1;
		end
	end

endmodule

// ----- src/tile_map_palette_upload_planner.sv -----
// ----------------------------------------------------------------------------
// tile_map_palette_upload_planner
// Plans per-frame video memory uploads (tile chunks, centered map rows with
// translated map words, palette) under a per-command byte budget.
// ----------------------------------------------------------------------------
// Usage:
//  - Config: cfg_valid/cfg_ready write beat, cfg_index selects the register,
//    cfg_data carries the value. cfg_ready is always high. Write only while
//    the planner is idle.
//  - Input: one beat per command (cmd, budget, map_index, map_value), taken
//    when in_valid is high and in_stall is low. in_stall is low only while
//    the sequencer waits in its fetch step.
//  - Output: one beat per result, taken when out_valid is high and out_stall
//    is low. A map row command gives the row descriptor then one word beat
//    per column; last marks the final beat of a command. Load gives none.
//  - Sequencing: the step program dispatches in up to seven steps and the map
//    RAM feeds one word per cycle while the output is not stalled. A command
//    holds the sequencer, with in_stall high, until its last step is done.
//  - A stalled output holds its beat; the sequencer waits on emit steps.
//  - Reset clears plan progress, restores config defaults and empties the
//    output register. Map RAM content is not cleared.
// ----------------------------------------------------------------------------
module tile_map_palette_upload_planner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] budget,
	input  logic [10:0] map_index,
	input  logic [15:0] map_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        mem_kind,
	output logic [15:0] dest_addr,
	output logic [1:0]  source_select,
	output logic [13:0] source_offset,
	output logic [15:0] byte_count,
	output logic [15:0] map_word,
	output logic        word_flag,
	output logic        last,
	output logic        complete,
	output logic [15:0] plane_b_reg
);

	tmpu_pkg::ctrl_t  ctrl;
	tmpu_pkg::flags_t flags;

	// config registers
	logic [8:0]  frame_width_q;
	logic [7:0]  frame_height_q;
	logic [9:0]  tile_count_q;
	logic [10:0] map_count_q;
	logic        bank_select_q;

	// plan state
	logic [14:0] tile_bytes_sent_q;
	logic [4:0]  map_row_next_q;
	logic        palette_sent_q;
	logic        plan_active_q;
	logic        plan_bank_q;
	logic [5:0]  col_q;
	logic [tmpu_pkg::MAP_AW-1:0] addr_q;

	// latched command
	logic [1:0]  cmd_q;
	logic [15:0] budget_q;
	logic [10:0] map_index_q;
	logic [15:0] map_value_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        mem_kind_q;
	logic [15:0] dest_addr_q;
	logic [1:0]  source_select_q;
	logic [13:0] source_offset_q;
	logic [15:0] byte_count_q;
	logic [15:0] map_word_q;
	logic        word_flag_q;
	logic        last_q;
	logic        complete_q;
	logic [15:0] plane_b_reg_q;

	logic        accept;
	logic        out_room;
	logic        fire;
	logic        emit_fire;

	logic [5:0]  cols;
	logic [4:0]  rows;
	logic        geo_ok;
	logic [14:0] total;
	logic [14:0] remaining;
	logic [15:0] take_raw;
	logic [15:0] take;
	logic [10:0] row_base;
	logic [15:0] map_x;
	logic [15:0] map_y;
	logic [15:0] map_dest;
	logic        more_words;

	logic                        ram_we;
	logic                        ram_re;
	logic [tmpu_pkg::MAP_AW-1:0] ram_raddr;
	logic [15:0]                 ram_rdata;

	logic [1:0]  nx_status;
	logic        nx_mem_kind;
	logic [15:0] nx_dest_addr;
	logic [1:0]  nx_source_select;
	logic [13:0] nx_source_offset;
	logic [15:0] nx_byte_count;
	logic [15:0] nx_map_word;
	logic        nx_word_flag;
	logic        nx_last;
	logic        nx_complete;
	logic [15:0] nx_plane_b_reg;

	assign cfg_ready = 1'b1;
	assign in_stall  = !ctrl.take;
	assign accept    = in_valid && ctrl.take;
	assign out_room  = !out_valid_q || !out_stall;
	assign fire      = !ctrl.emit || out_room;
	assign emit_fire = ctrl.emit && out_room;

	// geometry check against live registers
	assign cols = frame_width_q[8:3];
	assign rows = frame_height_q[7:3];
	assign geo_ok = (frame_width_q != 9'd0) && (frame_width_q[2:0] == 3'd0)
		&& (10'(frame_width_q) <= 10'(8 * tmpu_pkg::SCREEN_COLUMNS))
		&& (frame_height_q != 8'd0) && (frame_height_q[2:0] == 3'd0)
		&& (10'(frame_height_q) <= 10'(8 * tmpu_pkg::SCREEN_ROWS))
		&& (tile_count_q != 10'd0) && (tile_count_q <= 10'(tmpu_pkg::MAX_TILES))
		&& (map_count_q == 11'(cols) * 11'(rows));

	// tile chunk
	assign total     = {tile_count_q, 5'd0};
	assign remaining = (total > tile_bytes_sent_q) ? total - tile_bytes_sent_q : 15'd0;
	assign take_raw  = ({1'b0, remaining} < budget_q) ? {1'b0, remaining} : budget_q;
	assign take      = {take_raw[15:5], 5'd0};

	// map row placement
	assign row_base = 11'(map_row_next_q) * 11'(cols);
	assign map_x    = (16'(tmpu_pkg::SCREEN_COLUMNS) - 16'(cols)) >> 1;
	assign map_y    = ((16'(tmpu_pkg::SCREEN_ROWS) - 16'(rows)) >> 1) + 16'(map_row_next_q);
	assign map_dest = (plan_bank_q ? tmpu_pkg::MAP_BASE_B1 : tmpu_pkg::MAP_BASE_B0)
		+ {map_y[8:0], 7'd0} + {map_x[14:0], 1'b0};
	assign more_words = col_q != (cols - 6'd1);

	always_comb begin
		flags.no_item    = !in_valid;
		flags.is_start   = cmd_q == tmpu_pkg::CMD_START;
		flags.is_load    = cmd_q == tmpu_pkg::CMD_LOAD;
		flags.not_next   = cmd_q != tmpu_pkg::CMD_NEXT;
		flags.tile       = remaining != 15'd0;
		flags.map        = map_row_next_q < rows;
		flags.more_words = more_words;
		if (!plan_active_q || !geo_ok) begin
			flags.nothing = 1'b1;
		end else if (remaining != 15'd0) begin
			flags.nothing = take == 16'd0;
		end else if (map_row_next_q < rows) begin
			flags.nothing = budget_q < {9'd0, cols, 1'b0};
		end else begin
			flags.nothing = palette_sent_q || (budget_q < tmpu_pkg::PAL_BYTES);
		end
	end

	tmpu_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire),
		.flags   (flags),
		.ctrl    (ctrl)
	);

	assign ram_we    = (ctrl.op == tmpu_pkg::OP_LOAD)
		&& (13'(map_index_q) < 13'(tmpu_pkg::MAP_DEPTH));
	assign ram_re    = fire && ((ctrl.op == tmpu_pkg::OP_ROW) || (ctrl.op == tmpu_pkg::OP_WORD));
	assign ram_raddr = (ctrl.op == tmpu_pkg::OP_ROW) ? tmpu_pkg::MAP_AW'(row_base)
		: addr_q + tmpu_pkg::MAP_AW'(1);

	tmpu_ram #(
		.WIDTH (16),
		.DEPTH (tmpu_pkg::MAP_DEPTH)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (tmpu_pkg::MAP_AW'(map_index_q)),
		.wr_data (map_value_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// next result beat
	always_comb begin
		nx_status        = tmpu_pkg::ST_OK;
		nx_mem_kind      = tmpu_pkg::MEM_VRAM;
		nx_dest_addr     = 16'd0;
		nx_source_select = tmpu_pkg::SRC_TILE;
		nx_source_offset = 14'd0;
		nx_byte_count    = 16'd0;
		nx_map_word      = 16'd0;
		nx_word_flag     = 1'b0;
		nx_last          = 1'b1;
		nx_complete      = palette_sent_q;
		nx_plane_b_reg   = plan_bank_q ? tmpu_pkg::PLANE_B_B1 : tmpu_pkg::PLANE_B_B0;
		case (ctrl.op)
			tmpu_pkg::OP_START: begin
				if (geo_ok) begin
					nx_complete    = 1'b0;
					nx_plane_b_reg = bank_select_q ? tmpu_pkg::PLANE_B_B1
						: tmpu_pkg::PLANE_B_B0;
				end else begin
					nx_status = tmpu_pkg::ST_ARG;
				end
			end
			tmpu_pkg::OP_NOTHING: begin
				nx_status = tmpu_pkg::ST_NONE;
			end
			tmpu_pkg::OP_TILE: begin
				nx_dest_addr     = tmpu_pkg::TILE_BASE
					+ (plan_bank_q ? tmpu_pkg::TILE_BANK_STEP : 16'd0)
					+ {1'b0, tile_bytes_sent_q};
				nx_source_offset = tile_bytes_sent_q[13:0];
				nx_byte_count    = take;
			end
			tmpu_pkg::OP_ROW: begin
				nx_dest_addr     = map_dest;
				nx_source_select = tmpu_pkg::SRC_MAP;
				nx_byte_count    = {9'd0, cols, 1'b0};
				nx_last          = 1'b0;
			end
			tmpu_pkg::OP_WORD: begin
				nx_map_word  = (ram_rdata + 16'd1
					+ (plan_bank_q ? tmpu_pkg::BANK_TILE_OFS : 16'd0))
					| (plan_bank_q ? tmpu_pkg::BANK_FLAG : 16'd0);
				nx_word_flag = 1'b1;
				nx_last      = !more_words;
			end
			tmpu_pkg::OP_PALETTE: begin
				nx_mem_kind      = tmpu_pkg::MEM_CRAM;
				nx_dest_addr     = plan_bank_q ? tmpu_pkg::PAL_BANK_STEP : 16'd0;
				nx_source_select = tmpu_pkg::SRC_PAL;
				nx_byte_count    = tmpu_pkg::PAL_BYTES;
				nx_complete      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= tmpu_pkg::FRAME_WIDTH_RST;
			frame_height_q    <= tmpu_pkg::FRAME_HEIGHT_RST;
			tile_count_q      <= tmpu_pkg::TILE_COUNT_RST;
			map_count_q       <= tmpu_pkg::MAP_COUNT_RST;
			bank_select_q     <= tmpu_pkg::BANK_SELECT_RST;
			tile_bytes_sent_q <= 15'd0;
			map_row_next_q    <= 5'd0;
			palette_sent_q    <= 1'b0;
			plan_active_q     <= 1'b0;
			plan_bank_q       <= 1'b0;
			col_q             <= 6'd0;
			addr_q            <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tmpu_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
					tmpu_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[7:0];
					tmpu_pkg::CFG_TILE_COUNT:   tile_count_q   <= cfg_data[9:0];
					tmpu_pkg::CFG_MAP_COUNT:    map_count_q    <= cfg_data;
					tmpu_pkg::CFG_BANK_SELECT:  bank_select_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (fire) begin
				case (ctrl.op)
					tmpu_pkg::OP_START: begin
						if (geo_ok) begin
							plan_active_q     <= 1'b1;
							plan_bank_q       <= bank_select_q;
							tile_bytes_sent_q <= 15'd0;
							map_row_next_q    <= 5'd0;
							palette_sent_q    <= 1'b0;
						end
					end
					tmpu_pkg::OP_TILE: begin
						tile_bytes_sent_q <= tile_bytes_sent_q + take[14:0];
					end
					tmpu_pkg::OP_ROW: begin
						map_row_next_q <= map_row_next_q + 5'd1;
						col_q          <= 6'd0;
						addr_q         <= tmpu_pkg::MAP_AW'(row_base);
					end
					tmpu_pkg::OP_WORD: begin
						col_q  <= col_q + 6'd1;
						addr_q <= addr_q + tmpu_pkg::MAP_AW'(1);
					end
					tmpu_pkg::OP_PALETTE: begin
						palette_sent_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd;
			budget_q    <= budget;
			map_index_q <= map_index;
			map_value_q <= map_value;
		end
		if (emit_fire) begin
			status_q        <= nx_status;
			mem_kind_q      <= nx_mem_kind;
			dest_addr_q     <= nx_dest_addr;
			source_select_q <= nx_source_select;
			source_offset_q <= nx_source_offset;
			byte_count_q    <= nx_byte_count;
			map_word_q      <= nx_map_word;
			word_flag_q     <= nx_word_flag;
			last_q          <= nx_last;
			complete_q      <= nx_complete;
			plane_b_reg_q   <= nx_plane_b_reg;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign mem_kind      = mem_kind_q;
	assign dest_addr     = dest_addr_q;
	assign source_select = source_select_q;
	assign source_offset = source_offset_q;
	assign byte_count    = byte_count_q;
	assign map_word      = map_word_q;
	assign word_flag     = word_flag_q;
	assign last          = last_q;
	assign complete      = complete_q;
	assign plane_b_reg   = plane_b_reg_q;

	a_sent_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		tile_bytes_sent_q[4:0] == 5'd0)
		else $error("tile progress not 32-byte aligned");

	a_palette_needs_plan: assert property (@(posedge clk) disable iff (!arst_n)
		palette_sent_q |-> plan_active_q)
		else $error("palette sent without active plan");

	a_word_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == tmpu_pkg::OP_WORD) |-> (col_q < cols))
		else $error("map word column past row end");

	a_row_then_word: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && (ctrl.op == tmpu_pkg::OP_ROW)) |=> (ctrl.op == tmpu_pkg::OP_WORD))
		else $error("row descriptor not followed by map words");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile map palette upload planner. Preloads the
// map store, runs a table of corner cases (rejected geometry, empty budgets,
// tile count lowered mid-frame, both banks, palette and completion), then
// random frame plans with random sender gaps and receiver stalls. Every
// result beat is compared field by field against an in-bench planner model or a pinned row.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [1:0]  status;
		logic        mem_kind;
		logic [15:0] dest;
		logic [1:0]  src;
		logic [13:0] ofs;
		logic [15:0] bytes;
		logic [15:0] word;
		logic        wflag;
		logic        last;
		logic        complete;
		logic [15:0] plane_b;
	} upload_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [10:0] reg_val;
		logic [1:0]  op;
		logic [15:0] bud;
		logic [10:0] midx;
		logic [15:0] mval;
		bit          pinned;
		logic [1:0]  want_status;
		logic        want_complete;
		logic [15:0] want_plane_b;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [15:0] budget;
	logic [10:0] map_index;
	logic [15:0] map_value;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        mem_kind;
	logic [15:0] dest_addr;
	logic [1:0]  source_select;
	logic [13:0] source_offset;
	logic [15:0] byte_count;
	logic [15:0] map_word;
	logic        word_flag;
	logic        last;
	logic        complete;
	logic [15:0] plane_b_reg;

	tile_map_palette_upload_planner dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// planner model state
	logic [8:0]  cfg_width;
	logic [7:0]  cfg_height;
	logic [9:0]  cfg_tiles;
	logic [10:0] cfg_maps;
	logic        cfg_bank;
	logic [14:0] tile_sent;
	logic [4:0]  row_next;
	logic        pal_sent;
	logic        plan_on;
	logic        plan_bank;
	logic [15:0] map_mem [tmpu_pkg::MAP_DEPTH];

	upload_t planned_uploads[$];
	upload_t step_uploads[$];
	int      mismatches = 0;
	bit      send_calm = 1'b0;
	bit      recv_calm = 1'b0;

	function automatic int draw_pause(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic bit geometry_ok();
		int w, h;
		w = cfg_width;
		h = cfg_height;
		if (w == 0 || w > 8 * tmpu_pkg::SCREEN_COLUMNS || w % 8 != 0)
			return 1'b0;
		if (h == 0 || h > 8 * tmpu_pkg::SCREEN_ROWS || h % 8 != 0)
			return 1'b0;
		if (cfg_tiles == 0 || int'(cfg_tiles) > tmpu_pkg::MAX_TILES)
			return 1'b0;
		return int'(cfg_maps) == (w / 8) * (h / 8);
	endfunction

	function automatic void emit(logic [1:0] st, logic kind, logic [15:0] dest,
			logic [1:0] src, logic [13:0] ofs, logic [15:0] bytes, logic [15:0] word,
			logic wflag, logic lst);
		upload_t u;
		u.status   = st;
		u.mem_kind = kind;
		u.dest     = dest;
		u.src      = src;
		u.ofs      = ofs;
		u.bytes    = bytes;
		u.word     = word;
		u.wflag    = wflag;
		u.last     = lst;
		u.complete = pal_sent;
		u.plane_b  = plan_bank ? tmpu_pkg::PLANE_B_B1 : tmpu_pkg::PLANE_B_B0;
		step_uploads.push_back(u);
	endfunction

	task automatic predict_uploads(logic [1:0] op, logic [15:0] bud, logic [10:0] idx,
			logic [15:0] val);
		int          total, remaining, take, cols, rows, x, y, i;
		logic [15:0] raw, base;
		step_uploads.delete();
		case (op)
			tmpu_pkg::CMD_START: begin
				if (!geometry_ok()) begin
					emit(tmpu_pkg::ST_ARG, tmpu_pkg::MEM_VRAM, 16'd0, tmpu_pkg::SRC_TILE,
						14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
				end else begin
					plan_on   = 1'b1;
					plan_bank = cfg_bank;
					tile_sent = '0;
					row_next  = '0;
					pal_sent  = 1'b0;
					emit(tmpu_pkg::ST_OK, tmpu_pkg::MEM_VRAM, 16'd0, tmpu_pkg::SRC_TILE,
						14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
				end
			end
			tmpu_pkg::CMD_NEXT: begin
				total     = 32 * int'(cfg_tiles);
				remaining = total > int'(tile_sent) ? total - int'(tile_sent) : 0;
				take      = (remaining < int'(bud) ? remaining : int'(bud)) & ~31;
				cols      = int'(cfg_width) / 8;
				rows      = int'(cfg_height) / 8;
				if (!plan_on || !geometry_ok()) begin
					emit(tmpu_pkg::ST_NONE, tmpu_pkg::MEM_VRAM, 16'd0, tmpu_pkg::SRC_TILE,
						14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
				end else if (remaining != 0) begin
					if (take == 0) begin
						emit(tmpu_pkg::ST_NONE, tmpu_pkg::MEM_VRAM, 16'd0,
							tmpu_pkg::SRC_TILE, 14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
					end else begin
						emit(tmpu_pkg::ST_OK, tmpu_pkg::MEM_VRAM,
							16'(int'(tmpu_pkg::TILE_BASE)
								+ (plan_bank ? int'(tmpu_pkg::TILE_BANK_STEP) : 0)
								+ int'(tile_sent)),
							tmpu_pkg::SRC_TILE, 14'(tile_sent), 16'(take), 16'd0, 1'b0,
							1'b1);
						tile_sent = 15'(int'(tile_sent) + take);
					end
				end else if (int'(row_next) < rows) begin
					if (int'(bud) < cols * 2) begin
						emit(tmpu_pkg::ST_NONE, tmpu_pkg::MEM_VRAM, 16'd0,
							tmpu_pkg::SRC_TILE, 14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
					end else begin
						x    = (tmpu_pkg::SCREEN_COLUMNS - cols) / 2;
						y    = (tmpu_pkg::SCREEN_ROWS - rows) / 2 + int'(row_next);
						base = plan_bank ? tmpu_pkg::MAP_BASE_B1 : tmpu_pkg::MAP_BASE_B0;
						emit(tmpu_pkg::ST_OK, tmpu_pkg::MEM_VRAM,
							16'(int'(base) + y * 128 + x * 2), tmpu_pkg::SRC_MAP,
							14'd0, 16'(cols * 2), 16'd0, 1'b0, 1'b0);
						for (i = 0; i < cols; i++) begin
							raw = map_mem[int'(row_next) * cols + i];
							emit(tmpu_pkg::ST_OK, tmpu_pkg::MEM_VRAM, 16'd0,
								tmpu_pkg::SRC_TILE, 14'd0, 16'd0,
								16'((int'(raw) + 1
									+ (plan_bank ? int'(tmpu_pkg::BANK_TILE_OFS) : 0))
									| (plan_bank ? int'(tmpu_pkg::BANK_FLAG) : 0)),
								1'b1, i == cols - 1);
						end
						row_next = row_next + 5'd1;
					end
				end else if (!pal_sent && bud >= tmpu_pkg::PAL_BYTES) begin
					pal_sent = 1'b1;
					emit(tmpu_pkg::ST_OK, tmpu_pkg::MEM_CRAM,
						plan_bank ? tmpu_pkg::PAL_BANK_STEP : 16'd0, tmpu_pkg::SRC_PAL,
						14'd0, tmpu_pkg::PAL_BYTES, 16'd0, 1'b0, 1'b1);
				end else begin
					emit(tmpu_pkg::ST_NONE, tmpu_pkg::MEM_VRAM, 16'd0, tmpu_pkg::SRC_TILE,
						14'd0, 16'd0, 16'd0, 1'b0, 1'b1);
				end
			end
			tmpu_pkg::CMD_LOAD: begin
				if (int'(idx) < tmpu_pkg::MAP_DEPTH)
					map_mem[idx] = val;
			end
			default: ;
		endcase
	endtask

	task automatic send_item(logic [1:0] op, logic [15:0] bud, logic [10:0] idx,
			logic [15:0] val, bit pinned, upload_t pin);
		int n;
		n = draw_pause(send_calm);
		cfg_valid <= 1'b0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		cmd       <= op;
		budget    <= bud;
		map_index <= idx;
		map_value <= val;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_uploads(op, bud, idx, val);
		if (pinned)
			planned_uploads.push_back(pin);
		else
			foreach (step_uploads[k]) planned_uploads.push_back(step_uploads[k]);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [10:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tmpu_pkg::CFG_FRAME_WIDTH:  cfg_width  = val[8:0];
			tmpu_pkg::CFG_FRAME_HEIGHT: cfg_height = val[7:0];
			tmpu_pkg::CFG_TILE_COUNT:   cfg_tiles  = val[9:0];
			tmpu_pkg::CFG_MAP_COUNT:    cfg_maps   = val;
			tmpu_pkg::CFG_BANK_SELECT:  cfg_bank   = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait out every pending beat, plus a tail for commands that give none
	task automatic settle_planner(int extra);
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (planned_uploads.size() != 0);
		repeat (extra) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic stim_row_t cfg_row(logic [2:0] idx, logic [10:0] val);
		stim_row_t r;
		r = '{default: 0};
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic stim_row_t cmd_row(logic [1:0] op, logic [15:0] bud,
			logic [10:0] idx, logic [15:0] val);
		stim_row_t r;
		r = '{default: 0};
		r.op   = op;
		r.bud  = bud;
		r.midx = idx;
		r.mval = val;
		return r;
	endfunction

	function automatic stim_row_t pin_row(logic [1:0] op, logic [15:0] bud,
			logic [1:0] st, logic cmpl, logic [15:0] pb);
		stim_row_t r;
		r = cmd_row(op, bud, 11'd0, 16'd0);
		r.pinned        = 1'b1;
		r.want_status   = st;
		r.want_complete = cmpl;
		r.want_plane_b  = pb;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		upload_t want;
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			if (planned_uploads.size() == 0) begin
				$display("%0t: beat with nothing pending, expected none got status %h",
					$time, status);
				mismatches++;
			end else begin
				want = planned_uploads.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("mem_kind", 16'(want.mem_kind), 16'(mem_kind));
				check_field("dest_addr", want.dest, dest_addr);
				check_field("source_select", 16'(want.src), 16'(source_select));
				check_field("source_offset", 16'(want.ofs), 16'(source_offset));
				check_field("byte_count", want.bytes, byte_count);
				check_field("map_word", want.word, map_word);
				check_field("word_flag", 16'(want.wflag), 16'(word_flag));
				check_field("last", 16'(want.last), 16'(last));
				check_field("complete", 16'(want.complete), 16'(complete));
				check_field("plane_b_reg", want.plane_b, plane_b_reg);
			end
		end
	end

	initial begin
		int n;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			n = draw_pause(recv_calm);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && arst_n === 1'b1));
			@(negedge clk);
		end
	end

	initial begin
		stim_row_t   directed[$];
		stim_row_t   r;
		upload_t     pin;
		logic [15:0] b;
		int          issued, steps, cols, rows, pick;
		bit          was_cfg;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tmpu_pkg::CFG_FRAME_WIDTH;
		cfg_data  = '0;
		cmd       = tmpu_pkg::CMD_NEXT;
		budget    = '0;
		map_index = '0;
		map_value = '0;

		cfg_width  = tmpu_pkg::FRAME_WIDTH_RST;
		cfg_height = tmpu_pkg::FRAME_HEIGHT_RST;
		cfg_tiles  = tmpu_pkg::TILE_COUNT_RST;
		cfg_maps   = tmpu_pkg::MAP_COUNT_RST;
		cfg_bank   = tmpu_pkg::BANK_SELECT_RST;
		tile_sent  = '0;
		row_next   = '0;
		pal_sent   = 1'b0;
		plan_on    = 1'b0;
		plan_bank  = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every plan below stays within the first screen row of map entries
		for (int i = 0; i < tmpu_pkg::SCREEN_COLUMNS; i++)
			send_item(tmpu_pkg::CMD_LOAD, 16'($urandom()), 11'(i), 16'($urandom()), 1'b0,
				'0);

		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd0, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_WIDTH, 11'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_WIDTH, 11'd511));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_WIDTH, 11'd320));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_HEIGHT, 11'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_HEIGHT, 11'd255));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_HEIGHT, 11'd224));
		directed.push_back(cfg_row(tmpu_pkg::CFG_TILE_COUNT, 11'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_TILE_COUNT, 11'd1023));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_TILE_COUNT, 11'd512));
		directed.push_back(cfg_row(tmpu_pkg::CFG_MAP_COUNT, 11'd2047));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_ARG, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cfg_row(tmpu_pkg::CFG_MAP_COUNT, 11'd1120));
		directed.push_back(cfg_row(tmpu_pkg::CFG_BANK_SELECT, 11'd1));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_OK, 1'b0,
			tmpu_pkg::PLANE_B_B1));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd0, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B1));
		directed.push_back(cmd_row(tmpu_pkg::CMD_NEXT, 16'hFFFF, 11'd0, 16'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd79, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B1));
		directed.push_back(cmd_row(tmpu_pkg::CMD_NEXT, 16'd80, 11'd0, 16'd0));
		directed.push_back(cmd_row(tmpu_pkg::CMD_LOAD, 16'hFFFF, 11'd2047, 16'hFFFF));
		directed.push_back(cmd_row(CMD_UNUSED, 16'hFFFF, 11'd2047, 16'hFFFF));
		// tile count lowered under bytes already sent: no tile chunk, row budget short
		directed.push_back(cfg_row(tmpu_pkg::CFG_TILE_COUNT, 11'd1));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd79, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B1));
		// live geometry broken after start
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_WIDTH, 11'd8));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'hFFFF, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B1));
		directed.push_back(cfg_row(tmpu_pkg::CFG_FRAME_HEIGHT, 11'd8));
		directed.push_back(cfg_row(tmpu_pkg::CFG_MAP_COUNT, 11'd1));
		directed.push_back(cfg_row(tmpu_pkg::CFG_BANK_SELECT, 11'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_START, 16'd0, tmpu_pkg::ST_OK, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd31, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cmd_row(tmpu_pkg::CMD_NEXT, 16'd32, 11'd0, 16'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd1, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cmd_row(tmpu_pkg::CMD_NEXT, 16'd2, 11'd0, 16'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'd31, tmpu_pkg::ST_NONE, 1'b0,
			tmpu_pkg::PLANE_B_B0));
		directed.push_back(cmd_row(tmpu_pkg::CMD_NEXT, 16'd32, 11'd0, 16'd0));
		directed.push_back(pin_row(tmpu_pkg::CMD_NEXT, 16'hFFFF, tmpu_pkg::ST_NONE, 1'b1,
			tmpu_pkg::PLANE_B_B0));

		was_cfg = 1'b0;
		foreach (directed[k]) begin
			r = directed[k];
			if (r.is_cfg) begin
				if (!was_cfg)
					settle_planner(SETTLE_CYCLES);
				write_cfg(r.reg_idx, r.reg_val);
			end else begin
				pin          = '0;
				pin.status   = r.want_status;
				pin.last     = 1'b1;
				pin.complete = r.want_complete;
				pin.plane_b  = r.want_plane_b;
				send_item(r.op, r.bud, r.midx, r.mval, r.pinned, pin);
			end
			was_cfg = r.is_cfg;
		end

		issued = 0;
		while (issued < 56) begin
			settle_planner(SETTLE_CYCLES);
			if ($urandom_range(0, 9) < 8) begin
				cols = $urandom_range(0, 7) == 0 ? tmpu_pkg::SCREEN_COLUMNS
					: $urandom_range(1, 8);
				rows = cols == tmpu_pkg::SCREEN_COLUMNS ? 1 : $urandom_range(1, 4);
				write_cfg(tmpu_pkg::CFG_FRAME_WIDTH, 11'(cols * 8));
				write_cfg(tmpu_pkg::CFG_FRAME_HEIGHT, 11'(rows * 8));
				write_cfg(tmpu_pkg::CFG_TILE_COUNT, 11'($urandom_range(0, 7) == 0 ?
					$urandom_range(1, tmpu_pkg::MAX_TILES) : $urandom_range(1, 6)));
				write_cfg(tmpu_pkg::CFG_MAP_COUNT,
					11'(cols * rows + ($urandom_range(0, 9) == 0)));
				write_cfg(tmpu_pkg::CFG_BANK_SELECT, 11'($urandom_range(0, 1)));
			end else begin
				write_cfg(3'($urandom_range(0, 4)), 11'($urandom()));
			end
			if ($urandom_range(0, 3) != 0) begin
				send_item(tmpu_pkg::CMD_START, 16'($urandom()), 11'($urandom()),
					16'($urandom()), 1'b0, '0);
				issued++;
			end
			steps = $urandom_range(4, 16);
			repeat (steps) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					settle_planner(0);
				if (pick < 15) begin
					case ($urandom_range(0, 9))
						0:       b = 16'($urandom_range(0, 40));
						1:       b = 16'($urandom());
						default: b = 16'($urandom_range(80, 1024));
					endcase
					send_item(tmpu_pkg::CMD_NEXT, b, 11'($urandom()), 16'($urandom()),
						1'b0, '0);
					issued++;
				end else if (pick < 17) begin
					send_item(tmpu_pkg::CMD_LOAD, 16'($urandom()), 11'($urandom()),
						16'($urandom()), 1'b0, '0);
					issued++;
				end else if (pick < 18) begin
					send_item(tmpu_pkg::CMD_START, 16'($urandom()), 11'($urandom()),
						16'($urandom()), 1'b0, '0);
					issued++;
				end else begin
					send_item(CMD_UNUSED, 16'($urandom()), 11'($urandom()),
						16'($urandom()), 1'b0, '0);
				end
			end
		end

		settle_planner(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tmpu_pkg.sv
src/tmpu_ram.sv
src/tmpu_seq.sv
src/tile_map_palette_upload_planner.sv
tb/tb.sv
